@@ rtl/js_whitespace_minifier_assert.svh @@
// Assertion macros for the whitespace minifier checker.
// Plain text macros only; used by files that hold concurrent assertions.
`ifndef JS_WHITESPACE_MINIFIER_ASSERT_SVH
`define JS_WHITESPACE_MINIFIER_ASSERT_SVH

// Check under reset: property sampled on every rising edge, reset disables.
`define JSWM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jswm assertion failed");

// Check that also holds while reset is asserted.
`define JSWM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("jswm assertion failed");

`endif

@@ rtl/jswm_pkg.sv @@
// Shared types, byte constants and byte classes for the whitespace minifier.
// No dependencies.
package jswm_pkg;

  localparam logic [2:0] KindSpace   = 3'd0;
  localparam logic [2:0] KindNewline = 3'd1;
  localparam logic [2:0] KindBlock   = 3'd2;
  localparam logic [2:0] KindLine    = 3'd3;
  localparam logic [2:0] KindOther   = 3'd4;

  localparam logic CfgStripComments = 1'b0;
  localparam logic CfgStripSpaces   = 1'b1;

  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChSp     = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChUscore = 8'h5f;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChHigh   = 8'h7f;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig9   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7a;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrack = 8'h5d;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  typedef enum logic [1:0] {
    GapNone    = 2'd0,
    GapSpace   = 2'd1,
    GapNewline = 2'd2
  } gap_e;

  typedef struct packed {
    logic       gap;
    logic       gap_nl;
    logic [7:0] data;
  } jswm_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jswm_fifo_stat_t;

  function automatic logic is_word(logic [7:0] b);
    return (b >= ChDig0 && b <= ChDig9) || (b >= ChUpA && b <= ChUpZ) ||
           (b >= ChLoA && b <= ChLoZ) || b == ChUscore || b == ChDollar ||
           b == ChBslash || b >= ChHigh;
  endfunction

  function automatic logic nl_may_follow(logic [7:0] b);
    return is_word(b) || b == ChRBrace || b == ChRBrack || b == ChRParen ||
           b == ChPlus || b == ChMinus || b == ChDquote || b == ChSquote;
  endfunction

  function automatic logic nl_may_precede(logic [7:0] b);
    return is_word(b) || b == ChLBrace || b == ChLBrack || b == ChLParen ||
           b == ChPlus || b == ChMinus;
  endfunction

endpackage

@@ rtl/jswm_front.sv @@
// Front end: config registers, byte classification and gap tracking.
// Depends on jswm_pkg; writes one queue entry per byte that produces output.
module jswm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [2:0]           token_kind_i,
  input  logic                 first_of_token_i,
  input  logic [7:0]           data_byte_i,
  output logic                 push_o,
  output jswm_pkg::jswm_entry_t entry_o
);
  import jswm_pkg::*;

  logic       strip_c_q, strip_s_q;
  logic [7:0] last_q, last_d;
  gap_e       gap_q, gap_d;

  logic [2:0] kind;
  logic [7:0] b;
  logic       emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_c_q <= 1'b0;
      strip_s_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStripComments: strip_c_q <= cfg_wdata_i;
        CfgStripSpaces:   strip_s_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    kind        = (token_kind_i > KindLine) ? KindOther : token_kind_i;
    b           = data_byte_i;
    emit        = 1'b0;
    last_d      = last_q;
    gap_d       = gap_q;
    entry_o     = '0;
    entry_o.data = data_byte_i;
    if (strip_c_q && (kind == KindBlock || kind == KindLine) && !first_of_token_i) begin
      kind = KindOther;
      emit = 1'b0;
    end else begin
      if (strip_c_q && (kind == KindBlock || kind == KindLine)) begin
        b    = (kind == KindBlock) ? ChSp : ChNl;
        kind = (kind == KindBlock) ? KindSpace : KindNewline;
      end
      entry_o.data = b;
      if (!strip_s_q) begin
        emit = 1'b1;
        if (b != ChSp && b != ChTab) begin
          last_d = b;
        end
      end else if (kind == KindSpace) begin
        if (gap_q != GapSpace && gap_q != GapNewline) begin
          gap_d = is_word(last_q) ? GapSpace : GapNone;
        end
      end else if (kind == KindNewline) begin
        if (gap_q == GapSpace) begin
          gap_d = GapNewline;
        end else if (gap_q != GapNewline) begin
          gap_d = nl_may_follow(last_q) ? GapNewline : GapNone;
        end
      end else begin
        emit           = 1'b1;
        entry_o.gap    = (gap_q == GapNewline && nl_may_precede(b)) ||
                         (gap_q == GapSpace && is_word(b));
        entry_o.gap_nl = (gap_q == GapNewline);
        gap_d          = GapNone;
        last_d         = b;
      end
    end
  end

  assign push_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= ChNl;
      gap_q  <= GapNone;
    end else if (accept_i) begin
      last_q <= last_d;
      gap_q  <= gap_d;
    end
  end

endmodule

@@ rtl/jswm_queue.sv @@
// Short register queue of pending entries between front and back ends.
// Depends on jswm_pkg for the entry and status types.
module jswm_queue #(
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  jswm_pkg::jswm_entry_t    entry_i,
  input  logic                     pop_i,
  output jswm_pkg::jswm_entry_t    head_o,
  output jswm_pkg::jswm_fifo_stat_t stat_o
);
  import jswm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jswm_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/jswm_back.sv @@
// Back end: expands each queued entry into one or two result beats.
// Depends on jswm_pkg; drives the result side of the block.
module jswm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jswm_pkg::jswm_entry_t     head_i,
  input  jswm_pkg::jswm_fifo_stat_t stat_i,
  input  logic                      pop,
  output logic                      deq_o,
  output logic                      empty,
  output logic [7:0]                out_byte_o,
  output logic                      last_of_run_o
);
  import jswm_pkg::*;

  logic phase_q, phase_d;
  logic show_gap, take;

  assign empty         = stat_i.empty;
  assign show_gap      = head_i.gap && !phase_q;
  assign out_byte_o    = show_gap ? (head_i.gap_nl ? ChNl : ChSp) : head_i.data;
  assign last_of_run_o = !show_gap;
  assign take          = pop && !stat_i.empty;
  assign deq_o         = take && !show_gap;

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      phase_d = show_gap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/js_whitespace_minifier.sv @@
// Whitespace and comment minifier for classified JavaScript token bytes.
// Top level; depends on jswm_pkg, jswm_front, jswm_queue and jswm_back.
//
// Input side is a queue write: a beat is taken at a rising edge with push
// high and full low. Each beat carries token_kind_i, first_of_token_i and
// data_byte_i. Result side is a queue read: out_byte_o and last_of_run_o
// show the oldest result while empty is low, taken on an edge with pop high.
// An input beat yields zero, one or two result beats; last_of_run_o marks
// the final one of each input.
// Throughput: one input beat per cycle while full is low. The front end
// updates its gap state and writes any queue entry in the accepting cycle.
// An input that carries a held space or newline yields two result beats,
// absorbed by the QueueDepth-entry queue between front and back; full rises
// only when the queue fills because the receiver stalls or gaps pile up.
// Reset clears both strip bits, sets the last written byte to newline and
// drops any held gap and queued results. Write cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while no results are outstanding.
module js_whitespace_minifier #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [2:0] token_kind_i,
  input  logic       first_of_token_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import jswm_pkg::*;

  jswm_entry_t     entry, head;
  jswm_fifo_stat_t stat;
  logic            accept, q_push, q_pop;

  assign full   = stat.full;
  assign accept = push && !stat.full;

  jswm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .token_kind_i    (token_kind_i),
    .first_of_token_i(first_of_token_i),
    .data_byte_i     (data_byte_i),
    .push_o          (q_push),
    .entry_o         (entry)
  );

  jswm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(entry),
    .pop_i  (q_pop),
    .head_o (head),
    .stat_o (stat)
  );

  jswm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .stat_i       (stat),
    .pop          (pop),
    .deq_o        (q_pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

@@ rtl/jswm_checker.sv @@
// Port-level assertions for the whitespace minifier, bound to the top level.
// Depends on jswm_pkg and js_whitespace_minifier_assert.svh.
`include "js_whitespace_minifier_assert.svh"

module jswm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);
  import jswm_pkg::*;

  `JSWM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> empty && !full)

  `JSWM_ASSERT(a_gap_byte, clk_i, rst_ni,
               !empty && !last_of_run_o |-> out_byte_o == ChNl || out_byte_o == ChSp)

  `JSWM_ASSERT(a_gap_then_byte, clk_i, rst_ni,
               !empty && pop && !last_of_run_o |=> !empty && last_of_run_o)

  `JSWM_ASSERT(a_stall_hold, clk_i, rst_ni,
               !empty && !pop |=> !empty && $stable(out_byte_o) && $stable(last_of_run_o))

endmodule

bind js_whitespace_minifier jswm_checker u_checker (.*);
